/* rtl/ist_pkg.sv */
// Shared types and codes for integer_set_table.
// No dependencies.
`default_nettype none
package ist_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic cmp;
        logic shift;
        logic append;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/ist_cell.sv */
// One table slot: holds an entry, compares it to the key, shifts down on remove.
// Depends on ist_pkg.
`default_nettype none
module ist_cell (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ist_pkg::cell_ctrl_t                  ctrl,
    input  wire logic signed [ist_pkg::VALUE_W-1:0]   key,
    input  wire logic                                 in_range,
    input  wire logic                                 tail,
    input  wire logic signed [ist_pkg::VALUE_W-1:0]   up_entry,
    input  wire logic                                 carry_in,
    output logic                                      carry_out,
    output logic                                      hit,
    output logic signed [ist_pkg::VALUE_W-1:0]        entry
);

    logic signed [ist_pkg::VALUE_W-1:0] entry_reg;
    logic                               hit_reg;

    assign carry_out = carry_in | hit_reg;
    assign hit       = hit_reg;
    assign entry     = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.append && tail)
        begin
            entry_reg <= key;
        end
        else if (ctrl.shift && carry_out)
        begin
            entry_reg <= up_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            hit_reg <= in_range && (entry_reg == key);
        end
    end

endmodule
`default_nettype wire

/* rtl/integer_set_table.sv */
// Top level of integer_set_table: control FSM, count and a row of ist_cell slots.
// Depends on ist_pkg and ist_cell.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  command  | opcode, value                             | start high, busy low
//  result   | was_present, changed, full_reject, count  | done, one cycle, no stall
//
// One beat runs latch, compare in every slot, then update.
// The result shows on the cycle after the update; busy is low then, so the
// next command may start in that same cycle.
// Reset clears the count and FSM; entries are never cleared.
`default_nettype none
module integer_set_table #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           opcode,
    input  wire logic signed [ist_pkg::VALUE_W-1:0]   value,
    output logic                                      done,
    output logic                                      was_present,
    output logic                                      changed,
    output logic                                      full_reject,
    output logic [ist_pkg::COUNT_W-1:0]               count
);

    localparam int CW = $clog2(DEPTH + 1);

    ist_pkg::state_t                    state_reg, state_next;
    logic [1:0]                         op_reg;
    logic signed [ist_pkg::VALUE_W-1:0] key_reg;
    logic [CW-1:0]                      count_reg, count_next;
    logic                               done_reg;
    logic                               present_reg, changed_reg, reject_reg;
    logic                               present, full;
    logic                               do_append, do_remove;
    ist_pkg::cell_ctrl_t                ctrl;

    logic [DEPTH-1:0]                   hit_vec;
    logic [DEPTH:0]                     carry;
    logic signed [ist_pkg::VALUE_W-1:0] entry_vec [DEPTH];

    assign present = |hit_vec;
    assign full    = (count_reg == CW'(DEPTH));
    assign carry[0] = 1'b0;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [ist_pkg::VALUE_W-1:0] up_entry;
            if (i == DEPTH - 1)
            begin : g_last
                assign up_entry = entry_vec[i];
            end
            else
            begin : g_mid
                assign up_entry = entry_vec[i+1];
            end

            ist_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .key       (key_reg),
                .in_range  (CW'(i) < count_reg),
                .tail      (CW'(i) == count_reg),
                .up_entry  (up_entry),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .hit       (hit_vec[i]),
                .entry     (entry_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        do_append   = 1'b0;
        do_remove   = 1'b0;
        count_next  = count_reg;
        case (state_reg)
            ist_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ist_pkg::ST_CMP;
                end
            end
            ist_pkg::ST_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = ist_pkg::ST_UPD;
            end
            ist_pkg::ST_UPD:
            begin
                do_append   = (op_reg == ist_pkg::OP_ADD) && !present && !full;
                do_remove   = (op_reg == ist_pkg::OP_REMOVE) && present;
                ctrl.append = do_append;
                ctrl.shift  = do_remove;
                if (do_append)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if (do_remove)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = ist_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ist_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ist_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ist_pkg::ST_UPD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ist_pkg::ST_IDLE && start)
        begin
            op_reg  <= opcode;
            key_reg <= value;
        end
        if (state_reg == ist_pkg::ST_UPD)
        begin
            present_reg <= present;
            changed_reg <= do_append || do_remove;
            reject_reg  <= (op_reg == ist_pkg::OP_ADD) && !present && full;
        end
    end

    assign busy        = (state_reg != ist_pkg::ST_IDLE);
    assign done        = done_reg;
    assign was_present = present_reg;
    assign changed     = changed_reg;
    assign full_reject = reject_reg;

    generate
        if (CW >= ist_pkg::COUNT_W)
        begin : g_cnt_trunc
            assign count = count_reg[ist_pkg::COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign count = {{(ist_pkg::COUNT_W - CW){1'b0}}, count_reg};
        end
    endgenerate

`ifndef SYNTHESIS
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ist_pkg::ST_UPD |-> $onehot0(hit_vec))
        else $error("more than one slot matched the key");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above table depth");

    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ist_pkg::ST_UPD |=> done_reg && !busy)
        else $error("result not shown after update");

    a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && reject_reg |-> !changed_reg && !present_reg)
        else $error("rejected add reported a change");
`endif

endmodule
`default_nettype wire
